@@ design/rgbsc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the RGB555 scaler: beat payload types, register indexes,
// operation codes and the tap order. No dependencies.
package rgbsc_pkg;

  localparam int FRAME_WORDS_DEFAULT = 131072;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int STEP_W      = 24;
  localparam int DIM_W       = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_X_STEP         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_STEP         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_ON   = 3'd5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  // Tap order of a smoothed pixel; an unsmoothed one uses the centre only.
  localparam logic [2:0] TAP_CENTRE = 3'd0;
  localparam logic [2:0] TAP_LEFT   = 3'd1;
  localparam logic [2:0] TAP_RIGHT  = 3'd2;
  localparam logic [2:0] TAP_UP     = 3'd3;
  localparam logic [2:0] TAP_DOWN   = 3'd4;

  typedef struct packed {
    logic        op;
    logic [16:0] store_addr;
    logic [14:0] store_pixel;
    logic [11:0] disp_x;
    logic [11:0] disp_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_of_range;
  } out_item_t;

endpackage

@@ design/rgb555_scaler_with_smoothing.sv @@
`timescale 1ns / 1ps
// Nearest-neighbour RGB555 scaler with five-tap smoothing over a frame store.
// Depends on rgbsc_pkg.

// A write beat stores one RGB555 pixel; a render beat returns one 8-bit RGB
// pixel scaled from the frame store. Writes and unsmoothed renders issue one
// tap each, so one beat can be accepted every cycle while the pipeline
// advances. A smoothed render holds the item stage while its five taps are
// read one per cycle from the single port of the frame store. A result passes
// the item stage, stages M1, M2 and M3, the store read and stage D before the
// result register takes it. Writes and reads reach the store in beat order, so
// a render sees every write accepted before it and none after it. The result
// register holds a finished pixel while out_stall is high, and the pipeline
// keeps taking beats until the next finished pixel would need that register.
module rgb555_scaler_with_smoothing
  import rgbsc_pkg::*;
#(
  parameter int FRAME_WORDS = FRAME_WORDS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  localparam int AW         = $clog2(FRAME_WORDS);
  localparam int CRD_W      = 13;                  // display coordinate plus one
  localparam int PROD_W     = CRD_W + STEP_W;      // coordinate times step
  localparam int SRC_W      = PROD_W - 12;         // source column or row
  localparam int ROWADR_W   = SRC_W + DIM_W;       // row times stride
  localparam int ADDR_SUM_W = ROWADR_W + 1;

  // Configuration registers.
  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;
  logic [DIM_W-1:0]  source_width;
  logic [DIM_W-1:0]  display_width;
  logic [DIM_W-1:0]  display_height;
  logic              smoothing_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_step         <= STEP_W'(4096);
      y_step         <= STEP_W'(4096);
      source_width   <= DIM_W'(256);
      display_width  <= DIM_W'(256);
      display_height <= DIM_W'(256);
      smoothing_on   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_STEP:         x_step         <= cfg_data;
        REG_Y_STEP:         y_step         <= cfg_data;
        REG_SOURCE_WIDTH:   source_width   <= cfg_data[DIM_W-1:0];
        REG_DISPLAY_WIDTH:  display_width  <= cfg_data[DIM_W-1:0];
        REG_DISPLAY_HEIGHT: display_height <= cfg_data[DIM_W-1:0];
        REG_SMOOTHING_ON:   smoothing_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic adv;
  logic accept;
  logic d_valid;
  logic d_last;

  assign adv = !(d_valid && d_last && out_valid && out_stall);

  // Item stage: holds a beat while its taps are issued.
  in_item_t   i_item;
  logic       i_valid;
  logic       i_filt;
  logic [2:0] i_tap;
  logic       i_last;
  logic       filt_in;

  assign i_last   = (i_tap == (i_filt ? TAP_DOWN : TAP_CENTRE));
  assign in_stall = !(adv && (!i_valid || i_last));
  assign accept   = in_valid && !in_stall;

  assign filt_in = smoothing_on && (in_data.op == OP_RENDER) &&
                   (in_data.disp_x != 12'd0) && (in_data.disp_y != 12'd0) &&
                   ({1'b0, in_data.disp_x} + 13'd1 < display_width) &&
                   ({1'b0, in_data.disp_y} + 13'd1 < display_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
      i_tap   <= TAP_CENTRE;
    end else if (adv) begin
      if (accept) begin
        i_valid <= 1'b1;
        i_tap   <= TAP_CENTRE;
      end else if (i_valid && i_last) begin
        i_valid <= 1'b0;
      end else if (i_valid) begin
        i_tap <= i_tap + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      i_item <= in_data;
      i_filt <= filt_in;
    end
  end

  // Tap coordinates and weighting shift for the current tap.
  logic [CRD_W-1:0] xt;
  logic [CRD_W-1:0] yt;
  logic [1:0]       tap_shift;

  always_comb begin
    xt = {1'b0, i_item.disp_x};
    yt = {1'b0, i_item.disp_y};
    case (i_tap)
      TAP_LEFT:  xt = {1'b0, i_item.disp_x} - 13'd1;
      TAP_RIGHT: xt = {1'b0, i_item.disp_x} + 13'd1;
      TAP_UP:    yt = {1'b0, i_item.disp_y} - 13'd1;
      TAP_DOWN:  yt = {1'b0, i_item.disp_y} + 13'd1;
      default: ;
    endcase
    // An unsmoothed pixel weighs eight, a smoothed centre four, neighbours one.
    if (!i_filt) begin
      tap_shift = 2'd3;
    end else if (i_tap == TAP_CENTRE) begin
      tap_shift = 2'd2;
    end else begin
      tap_shift = 2'd0;
    end
  end

  // Stage M1: coordinate products.
  logic              m1_valid;
  logic              m1_op;
  logic              m1_first;
  logic              m1_last;
  logic [1:0]        m1_shift;
  logic [16:0]       m1_waddr;
  logic [14:0]       m1_wpix;
  logic [PROD_W-1:0] m1_col_prod;
  logic [PROD_W-1:0] m1_row_prod;

  // Stage M2: row times stride.
  logic                m2_valid;
  logic                m2_op;
  logic                m2_first;
  logic                m2_last;
  logic [1:0]          m2_shift;
  logic [16:0]         m2_waddr;
  logic [14:0]         m2_wpix;
  logic [SRC_W-1:0]    m2_col;
  logic [ROWADR_W-1:0] m2_row_prod;

  // Stage M3: word address and range check.
  logic          m3_valid;
  logic          m3_op;
  logic          m3_first;
  logic          m3_last;
  logic [1:0]    m3_shift;
  logic [14:0]   m3_wpix;
  logic [AW-1:0] m3_addr;
  logic          m3_bad;

  logic [ADDR_SUM_W-1:0] addr_sum;

  assign addr_sum = (m2_op == OP_WRITE) ? ADDR_SUM_W'(m2_waddr) :
                    ADDR_SUM_W'(m2_row_prod) + ADDR_SUM_W'(m2_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= i_valid;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_op       <= i_item.op;
      m1_first    <= (i_tap == TAP_CENTRE);
      m1_last     <= i_last;
      m1_shift    <= tap_shift;
      m1_waddr    <= i_item.store_addr;
      m1_wpix     <= i_item.store_pixel;
      m1_col_prod <= PROD_W'(xt) * PROD_W'(x_step);
      m1_row_prod <= PROD_W'(yt) * PROD_W'(y_step);

      m2_op       <= m1_op;
      m2_first    <= m1_first;
      m2_last     <= m1_last;
      m2_shift    <= m1_shift;
      m2_waddr    <= m1_waddr;
      m2_wpix     <= m1_wpix;
      m2_col      <= m1_col_prod[PROD_W-1:12];
      m2_row_prod <= ROWADR_W'(m1_row_prod[PROD_W-1:12]) * ROWADR_W'(source_width);

      m3_op    <= m2_op;
      m3_first <= m2_first;
      m3_last  <= m2_last;
      m3_shift <= m2_shift;
      m3_wpix  <= m2_wpix;
      m3_addr  <= addr_sum[AW-1:0];
      m3_bad   <= (addr_sum >= ADDR_SUM_W'(FRAME_WORDS));
    end
  end

  // Frame store: single port, one access per cycle while the pipeline advances, in beat order.
  logic [14:0] frame_store [FRAME_WORDS];
  logic [14:0] rdata;

  always_ff @(posedge clk) begin
    if (adv && m3_valid) begin
      if (m3_op == OP_WRITE) begin
        if (!m3_bad) begin
          frame_store[m3_addr] <= m3_wpix;
        end
      end else begin
        rdata <= frame_store[m3_addr];
      end
    end
  end

  // Stage D: read data arrives and is accumulated per channel.
  logic       d_first;
  logic [1:0] d_shift;
  logic       d_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= m3_valid && (m3_op == OP_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_first <= m3_first;
      d_last  <= m3_last;
      d_shift <= m3_shift;
      d_bad   <= m3_bad;
    end
  end

  // Sums stay within eleven bits: eight times the largest channel is 1984.
  logic [10:0] acc_r, acc_g, acc_b;
  logic        acc_bad;
  logic [10:0] sum_r, sum_g, sum_b;
  logic        sum_bad;

  always_comb begin
    sum_r   = (d_first ? 11'd0 : acc_r) + (11'({rdata[4:0],   3'b000}) << d_shift);
    sum_g   = (d_first ? 11'd0 : acc_g) + (11'({rdata[9:5],   3'b000}) << d_shift);
    sum_b   = (d_first ? 11'd0 : acc_b) + (11'({rdata[14:10], 3'b000}) << d_shift);
    sum_bad = (!d_first && acc_bad) || d_bad;
  end

  always_ff @(posedge clk) begin
    if (adv && d_valid) begin
      acc_r   <= sum_r;
      acc_g   <= sum_g;
      acc_b   <= sum_b;
      acc_bad <= sum_bad;
    end
  end

  // Result register. The weights add up to eight, so the sum over eight never
  // exceeds 248 and no clamp is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_valid && d_last && adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (d_valid && d_last && adv) begin
      out_data.red          <= sum_bad ? 8'd0 : sum_r[10:3];
      out_data.green        <= sum_bad ? 8'd0 : sum_g[10:3];
      out_data.blue         <= sum_bad ? 8'd0 : sum_b[10:3];
      out_data.out_of_range <= sum_bad;
    end
  end

endmodule

@@ dv/rgb555_scaler_with_smoothing_test.sv @@
`timescale 1ns / 1ps
// Testbench for the RGB555 scaler with five-tap smoothing: directed and random beats,
// checked against a predictor of the frame store and scaling arithmetic.
// Depends on rgbsc_pkg and rgb555_scaler_with_smoothing.

module rgb555_scaler_with_smoothing_test
  import rgbsc_pkg::*;
();

  localparam int FRAME_WORDS   = FRAME_WORDS_DEFAULT;
  localparam int TOTAL_ITEMS   = 850;
  localparam int PHASE_ITEMS   = 70;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int REPORT_CAP    = 40;

  // Holds the predicted frame store and registers, and the pixels still owed by the block.
  class render_scoreboard;
    logic [14:0]        frame_words [FRAME_WORDS];
    logic [STEP_W-1:0]  x_step;
    logic [STEP_W-1:0]  y_step;
    logic [DIM_W-1:0]   source_width;
    logic [DIM_W-1:0]   display_width;
    logic [DIM_W-1:0]   display_height;
    logic               smoothing_on;
    longint unsigned    tap_addr [5];
    out_item_t          expected_pixels [$];
    int                 mismatches;

    function new();
      x_step         = 24'd4096;
      y_step         = 24'd4096;
      source_width   = 13'd256;
      display_width  = 13'd256;
      display_height = 13'd256;
      smoothing_on   = 1'b0;
      mismatches     = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_X_STEP:         x_step = value;
        REG_Y_STEP:         y_step = value;
        REG_SOURCE_WIDTH:   source_width = value[DIM_W-1:0];
        REG_DISPLAY_WIDTH:  display_width = value[DIM_W-1:0];
        REG_DISPLAY_HEIGHT: display_height = value[DIM_W-1:0];
        REG_SMOOTHING_ON:   smoothing_on = value[0];
        default: ;
      endcase
    endfunction

    // Fills tap_addr with the word addresses a render of (x, y) reads and returns
    // how many there are: five for a smoothed interior pixel, otherwise one.
    function int tap_list(logic [11:0] x, logic [11:0] y);
      longint unsigned xx;
      longint unsigned yy;
      longint unsigned col;
      longint unsigned row;
      xx = 64'(x);
      yy = 64'(y);
      col = (xx * x_step) >> 12;
      row = (yy * y_step) >> 12;
      tap_addr[TAP_CENTRE] = row * source_width + col;
      if (!(smoothing_on && xx >= 1 && xx + 1 < display_width &&
            yy >= 1 && yy + 1 < display_height))
        return 1;
      tap_addr[TAP_LEFT]  = row * source_width + (((xx - 1) * x_step) >> 12);
      tap_addr[TAP_RIGHT] = row * source_width + (((xx + 1) * x_step) >> 12);
      tap_addr[TAP_UP]    = (((yy - 1) * y_step) >> 12) * source_width + col;
      tap_addr[TAP_DOWN]  = (((yy + 1) * y_step) >> 12) * source_width + col;
      return 5;
    endfunction

    function void take_beat(in_item_t b);
      int          n;
      int          w;
      int          r;
      int          g;
      int          bl;
      bit          bad;
      logic [14:0] p;
      out_item_t   want;
      if (b.op == OP_WRITE) begin
        if (b.store_addr < FRAME_WORDS) frame_words[b.store_addr] = b.store_pixel;
        return;
      end
      n = tap_list(b.disp_x, b.disp_y);
      r = 0;
      g = 0;
      bl = 0;
      bad = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (tap_addr[i] >= FRAME_WORDS) begin
          bad = 1'b1;
        end else begin
          p = frame_words[tap_addr[i]];
          w = (n == 5 && i == TAP_CENTRE) ? 4 : 1;
          r  += w * int'({p[4:0], 3'b000});
          g  += w * int'({p[9:5], 3'b000});
          bl += w * int'({p[14:10], 3'b000});
        end
      end
      if (n == 5) begin
        r  = (r >> 3) > 255 ? 255 : r >> 3;
        g  = (g >> 3) > 255 ? 255 : g >> 3;
        bl = (bl >> 3) > 255 ? 255 : bl >> 3;
      end
      if (bad) begin
        r = 0;
        g = 0;
        bl = 0;
      end
      want.red = r[7:0];
      want.green = g[7:0];
      want.blue = bl[7:0];
      want.out_of_range = bad;
      expected_pixels.push_back(want);
    endfunction

    task report_mismatch(string what);
      if (mismatches < REPORT_CAP) $display("%0t: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %0h %0h %0h flag %0b arrived with none owed",
                                  got.red, got.green, got.blue, got.out_of_range));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red)
        report_mismatch($sformatf("red %0h, expected %0h", got.red, want.red));
      if (got.green !== want.green)
        report_mismatch($sformatf("green %0h, expected %0h", got.green, want.green));
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue %0h, expected %0h", got.blue, want.blue));
      if (got.out_of_range !== want.out_of_range)
        report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                  got.out_of_range, want.out_of_range));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b1;
  out_item_t              out_data;

  render_scoreboard board;
  bit               primed [FRAME_WORDS];
  int               items_sent = 0;
  int               send_idle_pct = 33;
  int               recv_stall_pct = 71;
  int               hold_left = 0;
  bit               hold_request = 1'b0;
  int               quiet = 0;

  rgb555_scaler_with_smoothing #(
    .FRAME_WORDS(FRAME_WORDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off when the stimulus asks for it.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (in_valid && !in_stall) board.take_beat(in_data);
      if (out_valid && !out_stall) board.check_pixel(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_beat(in_item_t b);
    if (items_sent < TOTAL_ITEMS / 3) begin
      send_idle_pct = 33;
      recv_stall_pct = 71;
    end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
      send_idle_pct = 71;
      recv_stall_pct = 33;
    end else begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Waits until every owed pixel has come back and the pipeline has had time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.set_register(idx, value);
  endtask

  task automatic apply_setting(logic [STEP_W-1:0] xs, logic [STEP_W-1:0] ys,
                               logic [DIM_W-1:0] sw, logic [DIM_W-1:0] dw,
                               logic [DIM_W-1:0] dh, logic smooth);
    settle();
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(sw));
    write_reg(REG_DISPLAY_WIDTH, CFG_DATA_W'(dw));
    write_reg(REG_DISPLAY_HEIGHT, CFG_DATA_W'(dh));
    write_reg(REG_SMOOTHING_ON, CFG_DATA_W'(smooth));
    cfg_we <= 1'b0;
  endtask

  task automatic store_write(int addr, int pixel);
    in_item_t b;
    b.op = OP_WRITE;
    b.store_addr = 17'(addr);
    b.store_pixel = 15'(pixel);
    b.disp_x = 12'($urandom);
    b.disp_y = 12'($urandom);
    if (addr < FRAME_WORDS) primed[addr] = 1'b1;
    send_beat(b);
  endtask

  // Every tap inside the store is written before the render, so no unwritten word is read.
  task automatic render(int x, int y);
    longint unsigned taps [5];
    int              n;
    in_item_t        b;
    n = board.tap_list(12'(x), 12'(y));
    for (int i = 0; i < n; i++) taps[i] = board.tap_addr[i];
    for (int i = 0; i < n; i++)
      if (taps[i] < FRAME_WORDS && !primed[taps[i]])
        store_write(int'(taps[i]), $urandom_range(0, 15'h7FFF));
    b.op = OP_RENDER;
    b.store_addr = 17'($urandom);
    b.store_pixel = 15'($urandom);
    b.disp_x = 12'(x);
    b.disp_y = 12'(y);
    send_beat(b);
  endtask

  function automatic logic [STEP_W-1:0] rand_step();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return STEP_W'($urandom_range(1024, 8192));
    if (pick < 8) return STEP_W'($urandom_range(256, 65536));
    return STEP_W'($urandom);
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    if ($urandom_range(3) == 0) return DIM_W'($urandom_range(0, 4));
    return DIM_W'($urandom_range(3, 4096));
  endfunction

  function automatic int near_border(int d);
    int v;
    if ($urandom_range(1)) v = $urandom_range(0, 1);
    else v = d - int'($urandom_range(0, 2));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  initial begin
    int              phase;
    int              span_end;
    int              pick;
    int              x;
    int              y;
    bit              held;
    longint unsigned colmax;
    longint unsigned rowmax;
    longint unsigned xmax;
    longint unsigned ymax;
    board = new();
    held = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: unit steps, 256-pixel rows, no smoothing.
    store_write(0, 15'h7FFF);
    store_write(17'h1FFFF, 15'h0000);
    store_write(257, 15'h001F);
    render(0, 0);
    render(4095, 4095);
    render(255, 511);
    render(1, 1);

    // A non-unit column step shows whether border rows and columns use the right offset.
    apply_setting(24'd6144, 24'd4096, 13'd256, 13'd256, 13'd256, 1'b1);
    render(1, 1);
    render(7, 0);
    render(255, 7);
    render(254, 254);

    // Zero source width folds every row onto row zero.
    apply_setting(24'd4096, 24'd4096, 13'd0, 13'd3, 13'd3, 1'b1);
    render(1, 1);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (phase)
        0: apply_setting(24'd4096, 24'd4096, 13'd256, 13'd256, 13'd256, 1'b1);
        1: apply_setting(24'd0, 24'hFFFFFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b1);
        2: apply_setting(24'hFFFFFF, 24'd0, 13'd0, 13'd0, 13'd0, 1'b0);
        3: apply_setting(24'd1024, 24'd2048, 13'd4096, 13'd4096, 13'd4096, 1'b1);
        4: apply_setting(24'd4096, 24'd4096, 13'd1, 13'd1, 13'd2, 1'b1);
        default: apply_setting(rand_step(), rand_step(),
                               ($urandom_range(9) < 7) ? DIM_W'($urandom_range(1, 512))
                                                       : DIM_W'($urandom_range(1, 4096)),
                               rand_dim(), rand_dim(), $urandom_range(3) != 0);
      endcase

      // Coordinate window that keeps most taps inside the store under this setting.
      colmax = (board.source_width == 0) ? FRAME_WORDS : board.source_width;
      rowmax = (board.source_width == 0) ? 64'd1 << 40 : FRAME_WORDS / board.source_width;
      xmax = (board.x_step == 0) ? 4095 : colmax * 4096 / board.x_step;
      ymax = (board.y_step == 0) ? 4095 : rowmax * 4096 / board.y_step;
      if (xmax > 4095) xmax = 4095;
      if (ymax > 4095) ymax = 4095;

      span_end = items_sent + PHASE_ITEMS;
      while (items_sent < span_end && items_sent < TOTAL_ITEMS) begin
        if (!held && items_sent >= 2 * TOTAL_ITEMS / 3 + 20) begin
          hold_request = 1'b1;
          held = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 18) begin
          store_write($urandom_range(0, 17'h1FFFF), $urandom_range(0, 15'h7FFF));
        end else begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            x = $urandom_range(0, 32'(xmax));
            y = $urandom_range(0, 32'(ymax));
          end else if (pick < 70) begin
            x = near_border(int'(board.display_width));
            y = near_border(int'(board.display_height));
          end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
          end
          render(x, y);
        end
      end
      phase++;
    end

    settle();
    if (board.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
